[design/pfc_pkg.sv]
package pfc_pkg;

  localparam int FrameW = 56;
  localparam int ValueW = 32;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;
  typedef logic [7:0] byte_t;

  localparam cmd_t CMD_ENCODE = 2'd0;
  localparam cmd_t CMD_DECODE = 2'd1;
  localparam cmd_t CMD_LOAD   = 2'd2;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_BAD_TYPE = 2'd1;
  localparam status_t STATUS_BAD_SUM  = 2'd2;

  localparam byte_t FILL_B3 = 8'h69;
  localparam byte_t FILL_B4 = 8'h96;
  localparam byte_t FILL_B5 = 8'h99;

  localparam byte_t TYPE_LEN4 = 8'hAA;
  localparam byte_t TYPE_LEN3 = 8'hA5;
  localparam byte_t TYPE_LEN2 = 8'h5A;
  localparam byte_t TYPE_LEN1 = 8'h55;

  typedef struct packed {
    logic [FrameW-1:0] tx_frame;
    logic [ValueW-1:0] rx_value;
    status_t           status;
  } result_t;

  // byte k of a frame, byte 0 in the top bits
  function automatic byte_t frame_byte(input logic [FrameW-1:0] f, input int k);
    return f[FrameW-1-8*k -: 8];
  endfunction

  function automatic byte_t permute_key(input byte_t k);
    return {k[2], k[4], k[0], k[6], k[1], k[7], k[3], k[5]};
  endfunction

endpackage

[design/pfc_if.sv]
interface pfc_in_if import pfc_pkg::*; ();
  logic              valid;
  logic              ready;
  cmd_t              cmd;
  logic [5:0]        param_id;
  logic [ValueW-1:0] param_value;
  logic [FrameW-1:0] rx_frame;

  modport source(output valid, cmd, param_id, param_value, rx_frame, input ready);
  modport sink(input valid, cmd, param_id, param_value, rx_frame, output ready);
endinterface

interface pfc_out_if import pfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FrameW-1:0] tx_frame;
  logic [ValueW-1:0] rx_value;
  status_t           status;

  modport source(output valid, tx_frame, rx_value, status, input ready);
  modport sink(input valid, tx_frame, rx_value, status, output ready);
endinterface

[design/parameter_frame_codec.sv]
// a request passes the input register, then the result register, before it can be accepted as a result
// throughput: one request per cycle while result.ready holds; the key register is updated as a request
//   moves into the result register, so the next request sees the new key
// reset: rst (synchronous, active high) empties both registers and clears the key to zero
module parameter_frame_codec import pfc_pkg::*; (
  input logic       clk,
  input logic       rst,
  pfc_in_if.sink    request,
  pfc_out_if.source result
);

  logic              s1_valid;
  cmd_t              s1_cmd;
  logic [5:0]        s1_id;
  logic [ValueW-1:0] s1_value;
  logic [FrameW-1:0] s1_frame;

  byte_t             key;
  byte_t             key_next;
  logic              out_valid;
  result_t           out_data;
  result_t           res_next;

  logic              advance;
  logic [FrameW-1:0] enc_frame;
  byte_t             dec_key;
  logic [ValueW-1:0] dec_value;
  status_t           dec_status;

  assign advance       = s1_valid && (!out_valid || result.ready);
  assign request.ready = !s1_valid || advance;

  pfc_encode u_encode (
    .key         (key),
    .param_id    (s1_id),
    .param_value (s1_value),
    .tx_frame    (enc_frame)
  );

  pfc_decode u_decode (
    .rx_frame (s1_frame),
    .key_new  (dec_key),
    .rx_value (dec_value),
    .status   (dec_status)
  );

  always_comb begin
    key_next = key;
    res_next = '0;
    unique case (s1_cmd)
      CMD_ENCODE: res_next.tx_frame = enc_frame;
      CMD_DECODE: begin
        key_next          = dec_key;
        res_next.rx_value = dec_value;
        res_next.status   = dec_status;
      end
      CMD_LOAD: key_next = frame_byte(s1_frame, 3);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      key       <= '0;
    end else begin
      if (request.ready) begin
        s1_valid <= request.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        key       <= key_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      s1_cmd   <= request.cmd;
      s1_id    <= request.param_id;
      s1_value <= request.param_value;
      s1_frame <= request.rx_frame;
    end
    if (advance) begin
      out_data <= res_next;
    end
  end

  assign result.valid    = out_valid;
  assign result.tx_frame = out_data.tx_frame;
  assign result.rx_value = out_data.rx_value;
  assign result.status   = out_data.status;

endmodule

[design/pfc_encode.sv]
module pfc_encode import pfc_pkg::*; (
  input  byte_t             key,
  input  logic [5:0]        param_id,
  input  logic [ValueW-1:0] param_value,
  output logic [FrameW-1:0] tx_frame
);

  byte_t      b0, b1, b2, b3, b4, b5, b6;
  logic       z3, z4, z5;
  logic [1:0] len;

  always_comb begin
    // leading zero bytes of the top three become fillers, each one shortens the length
    z3 = (param_value[31:24] == 8'h00);
    z4 = z3 && (param_value[23:16] == 8'h00);
    z5 = z4 && (param_value[15:8] == 8'h00);
    b3 = (z3 ? FILL_B3 : param_value[31:24]) ^ key;
    b4 = (z4 ? FILL_B4 : param_value[23:16]) ^ key;
    b5 = (z5 ? FILL_B5 : param_value[15:8]) ^ key;
    b6 = param_value[7:0] ^ key;
    len = 2'd3 - 2'(z3) - 2'(z4) - 2'(z5);
    b1 = {param_id, len} ^ key;
    b0 = permute_key(key);
    b2 = b0 + b1 + b3 + b4 + b5 + b6;
    tx_frame = {b0, b1, b2, b3, b4, b5, b6};
  end

endmodule

[design/pfc_decode.sv]
module pfc_decode import pfc_pkg::*; (
  input  logic [FrameW-1:0] rx_frame,
  output byte_t             key_new,
  output logic [ValueW-1:0] rx_value,
  output status_t           status
);

  byte_t             b1, b2, b3, b4, b5, b6, sum;
  logic              known;
  logic [ValueW-1:0] v;

  always_comb begin
    key_new = ~frame_byte(rx_frame, 0);
    b1 = frame_byte(rx_frame, 1) ^ key_new;
    b2 = frame_byte(rx_frame, 2) ^ key_new;
    b3 = frame_byte(rx_frame, 3) ^ key_new;
    b4 = frame_byte(rx_frame, 4) ^ key_new;
    b5 = frame_byte(rx_frame, 5) ^ key_new;
    b6 = frame_byte(rx_frame, 6) ^ key_new;
    known = 1'b1;
    unique case (b1)
      TYPE_LEN4: v = {b3, b4, b5, b6};
      TYPE_LEN3: v = {8'h00, b4, b5, b6};
      TYPE_LEN2: v = {16'h0000, b5, b6};
      TYPE_LEN1: v = {24'h000000, b6};
      default: begin
        v = '0;
        known = 1'b0;
      end
    endcase
    // checksum covers all four data bytes whatever the width
    sum = key_new + b1 + b3 + b4 + b5 + b6;
    rx_value = '0;
    if (!known) begin
      status = STATUS_BAD_TYPE;
    end else if (sum != b2) begin
      status = STATUS_BAD_SUM;
    end else begin
      status = STATUS_OK;
      rx_value = v;
    end
  end

endmodule

[tb/sv/parameter_frame_codec_test.sv]
module parameter_frame_codec_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pfc_pkg::*;

  localparam cmd_t CmdUnused   = 2'd3;
  localparam int   NumDirected = 21;
  localparam int   NumRandom   = 1000;
  localparam int   IdlePct     = 7;

  typedef struct {
    cmd_t              cmd;
    logic [5:0]        id;
    logic [ValueW-1:0] value;
    logic [FrameW-1:0] frame;
    bit                typed;
    result_t           want;
  } stim_row_t;

  logic clk;
  logic rst;

  pfc_in_if  req_if ();
  pfc_out_if res_if ();

  parameter_frame_codec DUT (
    .clk    (clk),
    .rst    (rst),
    .request(req_if),
    .result (res_if)
  );

  byte_t     key_model;
  result_t   expected_results[$];
  result_t   popped;
  int        failures;
  bit        steady;
  stim_row_t directed_rows[NumDirected];
  byte_t     type_codes[4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("parameter_frame_codec regression: fail");
    $finish;
  end

  function automatic byte_t scramble_key(input byte_t k);
    byte_t s;
    s[0] = k[5];
    s[1] = k[3];
    s[2] = k[7];
    s[3] = k[1];
    s[4] = k[6];
    s[5] = k[0];
    s[6] = k[4];
    s[7] = k[2];
    return s;
  endfunction

  // well-formed received frame for a given key, type byte and value
  function automatic logic [FrameW-1:0] build_rx_frame(input byte_t k, input byte_t kind,
                                                       input logic [ValueW-1:0] v);
    byte_t csum;
    csum = k + kind + v[31:24] + v[23:16] + v[15:8] + v[7:0];
    return {~k, kind ^ k, csum ^ k, v[31:24] ^ k, v[23:16] ^ k, v[15:8] ^ k, v[7:0] ^ k};
  endfunction

  function automatic logic [FrameW-1:0] random_frame();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[FrameW-1:0];
  endfunction

  function automatic result_t codec_predict(input cmd_t c, input logic [5:0] id,
                                            input logic [ValueW-1:0] v,
                                            input logic [FrameW-1:0] f);
    result_t           r;
    byte_t             b[7];
    byte_t             len;
    byte_t             sum;
    logic [ValueW-1:0] dv;
    bit                known;
    int                i;
    r = '0;
    case (c)
      CMD_ENCODE: begin
        b[3] = v[31:24];
        b[4] = v[23:16];
        b[5] = v[15:8];
        b[6] = v[7:0];
        len = 8'd3;
        // leading zero bytes of the top three become fillers, one length step each
        if (b[3] == 8'h00) begin
          b[3] = FILL_B3;
          len = len - 8'd1;
          if (b[4] == 8'h00) begin
            b[4] = FILL_B4;
            len = len - 8'd1;
            if (b[5] == 8'h00) begin
              b[5] = FILL_B5;
              len = len - 8'd1;
            end
          end
        end
        b[1] = {id, len[1:0]} ^ key_model;
        for (i = 3; i < 7; i++) b[i] = b[i] ^ key_model;
        b[0] = scramble_key(key_model);
        b[2] = b[0] + b[1] + b[3] + b[4] + b[5] + b[6];
        r.tx_frame = {b[0], b[1], b[2], b[3], b[4], b[5], b[6]};
      end
      CMD_DECODE: begin
        key_model = ~f[55:48];
        for (i = 1; i < 7; i++) b[i] = f[55-8*i -: 8] ^ key_model;
        known = 1'b1;
        dv = '0;
        case (b[1])
          TYPE_LEN4: dv = {b[3], b[4], b[5], b[6]};
          TYPE_LEN3: dv = {8'h00, b[4], b[5], b[6]};
          TYPE_LEN2: dv = {16'h0000, b[5], b[6]};
          TYPE_LEN1: dv = {24'h000000, b[6]};
          default:   known = 1'b0;
        endcase
        if (!known) begin
          r.status = STATUS_BAD_TYPE;
        end else begin
          sum = key_model + b[1] + b[3] + b[4] + b[5] + b[6];
          if (sum == b[2]) begin
            r.rx_value = dv;
          end else begin
            r.status = STATUS_BAD_SUM;
          end
        end
      end
      CMD_LOAD: begin
        key_model = f[31:24];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic send_request(input cmd_t c, input logic [5:0] id,
                              input logic [ValueW-1:0] v, input logic [FrameW-1:0] f,
                              input bit typed, input result_t want);
    result_t model;
    while (!steady && $urandom_range(99) < IdlePct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.cmd         <= c;
    req_if.param_id    <= id;
    req_if.param_value <= v;
    req_if.rx_frame    <= f;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    // predictor runs on every request so the key stays in step
    model = codec_predict(c, id, v, f);
    expected_results.push_back(typed ? want : model);
  endtask

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= (steady || $urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending: tx_frame %h rx_value %h status %0d",
                 $time, res_if.tx_frame, res_if.rx_value, res_if.status);
        failures++;
      end else begin
        popped = expected_results.pop_front();
        if (res_if.tx_frame !== popped.tx_frame) begin
          $display("%0t: tx_frame expected %h actual %h", $time, popped.tx_frame,
                   res_if.tx_frame);
          failures++;
        end
        if (res_if.rx_value !== popped.rx_value) begin
          $display("%0t: rx_value expected %h actual %h", $time, popped.rx_value,
                   res_if.rx_value);
          failures++;
        end
        if (res_if.status !== popped.status) begin
          $display("%0t: status expected %0d actual %0d", $time, popped.status,
                   res_if.status);
          failures++;
        end
      end
    end
  end

  initial begin
    int                n;
    int                pick;
    int                shape;
    byte_t             rand_key;
    cmd_t              c;
    logic [5:0]        id;
    logic [ValueW-1:0] v;
    logic [FrameW-1:0] f;

    failures  = 0;
    key_model = 8'h00;
    steady    = 1'b0;
    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.cmd         <= CMD_ENCODE;
    req_if.param_id    <= '0;
    req_if.param_value <= '0;
    req_if.rx_frame    <= '0;

    type_codes = '{TYPE_LEN4, TYPE_LEN3, TYPE_LEN2, TYPE_LEN1};
    directed_rows = '{
      '{CMD_ENCODE, 6'd0,  32'h0000_0000, 56'h0, 1'b1, {56'h00009869969900, 32'h0, STATUS_OK}},
      '{CMD_ENCODE, 6'd63, 32'hFFFF_FFFF, 56'h0, 1'b1, {56'h00FFFBFFFFFFFF, 32'h0, STATUS_OK}},
      '{CMD_ENCODE, 6'h15, 32'h0000_0012, 56'h0, 1'b0, '0},
      '{CMD_ENCODE, 6'h2A, 32'h0000_1234, 56'h0, 1'b0, '0},
      '{CMD_ENCODE, 6'h01, 32'h0012_3456, 56'h0, 1'b0, '0},
      '{CMD_ENCODE, 6'h3E, 32'h1200_3400, 56'h0, 1'b0, '0},
      '{CMD_LOAD,   6'd0,  32'h0, 56'h000000FF000000, 1'b1, '0},
      '{CMD_ENCODE, 6'd0,  32'h0000_0000, 56'h0, 1'b0, '0},
      '{CMD_ENCODE, 6'd63, 32'hFFFF_FFFF, 56'h0, 1'b0, '0},
      // zero frame: key becomes all ones, type byte decrypts to an unknown code
      '{CMD_DECODE, 6'd0,  32'h0, 56'h0, 1'b1, {56'h0, 32'h0, STATUS_BAD_TYPE}},
      // zero key, valid type, checksum byte wrong
      '{CMD_DECODE, 6'd0,  32'h0, 56'hFFAA0000000000, 1'b1, {56'h0, 32'h0, STATUS_BAD_SUM}},
      '{CMD_DECODE, 6'd0,  32'h0, build_rx_frame(8'h00, TYPE_LEN4, 32'hDEAD_BEEF), 1'b0, '0},
      '{CMD_DECODE, 6'd0,  32'h0, build_rx_frame(8'hFF, TYPE_LEN3, 32'h00AB_CDEF), 1'b0, '0},
      '{CMD_DECODE, 6'd0,  32'h0, build_rx_frame(8'h5C, TYPE_LEN2, 32'h0000_FFFF), 1'b0, '0},
      '{CMD_DECODE, 6'd0,  32'h0, build_rx_frame(8'hA3, TYPE_LEN1, 32'h0000_00FF), 1'b0, '0},
      '{CMD_ENCODE, 6'h2B, 32'h8000_0001, 56'h0, 1'b0, '0},
      '{CmdUnused,  6'd63, 32'hFFFF_FFFF, 56'hFFFFFFFFFFFFFF, 1'b1, '0},
      '{CMD_ENCODE, 6'h1F, 32'h0000_0001, 56'h0, 1'b0, '0},
      '{CMD_LOAD,   6'd0,  32'h0, 56'hFFFFFFFFFFFFFF, 1'b1, '0},
      '{CMD_DECODE, 6'd0,  32'h0, 56'hFFFFFFFFFFFFFF, 1'b1, {56'h0, 32'h0, STATUS_BAD_TYPE}},
      '{CMD_ENCODE, 6'h0A, 32'h00FF_0000, 56'h0, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < NumDirected; n++) begin
      send_request(directed_rows[n].cmd, directed_rows[n].id, directed_rows[n].value,
                   directed_rows[n].frame, directed_rows[n].typed, directed_rows[n].want);
    end

    for (n = 0; n < NumRandom; n++) begin
      steady = (n >= 400 && n < 550);
      if (n == 700) begin
        // drain everything before going on
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
      end
      id = 6'($urandom_range(63));
      v = $urandom;
      shape = $urandom_range(5);
      case (shape)
        1: v = v >> 8;
        2: v = v >> 16;
        3: v = v >> 24;
        4: v = '0;
        default: begin
        end
      endcase
      f = random_frame();
      rand_key = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 30) begin
        c = CMD_ENCODE;
      end else if (pick < 75) begin
        c = CMD_DECODE;
        f = build_rx_frame(rand_key, type_codes[$urandom_range(3)], v);
        shape = $urandom_range(15);
        // a few broken frames: corrupted checksum or type byte
        if (shape == 0) begin
          f[39:32] = f[39:32] ^ 8'($urandom_range(255, 1));
        end else if (shape == 1) begin
          f[47:40] = f[47:40] ^ 8'($urandom_range(255, 1));
        end
        v = $urandom;
      end else if (pick < 85) begin
        c = CMD_LOAD;
      end else if (pick < 95) begin
        c = CMD_DECODE;
      end else begin
        c = CmdUnused;
      end
      send_request(c, id, v, f, 1'b0, '0);
    end

    steady = 1'b0;
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("parameter_frame_codec regression: pass");
    end else begin
      $display("parameter_frame_codec regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
design/pfc_pkg.sv
design/pfc_if.sv
design/pfc_encode.sv
design/pfc_decode.sv
design/parameter_frame_codec.sv
tb/sv/parameter_frame_codec_test.sv
